### rtl/timing_wheel_expiry_macros.svh
// Assertion macros shared by the timing wheel RTL.
`ifndef TIMING_WHEEL_EXPIRY_MACROS_SVH
`define TIMING_WHEEL_EXPIRY_MACROS_SVH

// Check that a property holds on every clock edge outside reset.
`define TWE_ASSERT(lbl, prop) lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("timing wheel check failed");

// Check that a condition never occurs outside reset.
`define TWE_NEVER(lbl, cond) lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("timing wheel forbidden condition");

`endif

### rtl/twe_pkg.sv
package twe_pkg;

    localparam int NUM_SLOTS   = 64;
    localparam int NUM_WAITERS = 64;
    localparam int SLOT_W      = 6;
    localparam int ID_W        = 6;
    localparam int CNT_W       = 7;

    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_INSERT  = 2'd1;
    localparam logic [1:0] OP_REFRESH = 2'd2;
    localparam logic [1:0] OP_REMOVE  = 2'd3;

    localparam logic ST_OK  = 1'b0;
    localparam logic ST_ERR = 1'b1;

    // slot entry: {first, final}; waiter entry: {after, before, home}
    localparam int SLOT_ENTRY_W   = 2 * ID_W;
    localparam int WAITER_ENTRY_W = 2 * ID_W + SLOT_W;

    localparam int REG_WHEEL_SLOTS = 0;

    typedef struct packed {
        logic [1:0]      operation;
        logic [ID_W-1:0] waiter_id;
    } in_item_t;

    typedef struct packed {
        logic             status;
        logic             expired_valid;
        logic [ID_W-1:0]  expired_id;
        logic [CNT_W-1:0] expired_count;
        logic [CNT_W-1:0] waiting_total;
        logic             last;
    } out_item_t;

endpackage

### rtl/twe_ram.sv
module twe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/timing_wheel_expiry.sv
// Timing wheel: tick, insert, refresh and remove over 64 waiter IDs in linked lists.
// Transactions are handled one at a time; a new one is taken only after the last result of the
// previous one has been accepted. Throughput is set by the single read port of the waiter memory
// and its registered read.
// Reset (rst_n, async, active low) clears slot, count, occupancy and active flags;
// the list memories are not cleared and need no clearing pass.
`include "timing_wheel_expiry_macros.svh"

module timing_wheel_expiry (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  twe_pkg::in_item_t   in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output twe_pkg::out_item_t  out_item,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int SW = twe_pkg::SLOT_W;
    localparam int IW = twe_pkg::ID_W;
    localparam int CW = twe_pkg::CNT_W;

    // Sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_OUT    = 4'd1;
    localparam logic [3:0] S_U_W    = 4'd2;
    localparam logic [3:0] S_U_S    = 4'd3;
    localparam logic [3:0] S_U_NB   = 4'd4;
    localparam logic [3:0] S_U_NARD = 4'd5;
    localparam logic [3:0] S_U_NA   = 4'd6;
    localparam logic [3:0] S_U_DONE = 4'd7;
    localparam logic [3:0] S_A_GO   = 4'd8;
    localparam logic [3:0] S_A_S    = 4'd9;
    localparam logic [3:0] S_A_TL   = 4'd10;
    localparam logic [3:0] S_A_RID  = 4'd11;
    localparam logic [3:0] S_A_ID   = 4'd12;
    localparam logic [3:0] S_T_SLOT = 4'd13;
    localparam logic [3:0] S_T_W    = 4'd14;

    localparam logic [CW-1:0] FULL = CW'(twe_pkg::NUM_WAITERS);
    localparam logic [CW-1:0] MAXS = CW'(twe_pkg::NUM_SLOTS);

    logic [3:0]    state_reg, state_next;
    logic [1:0]    op_reg, op_next;
    logic [IW-1:0] id_reg, id_next;
    logic [SW-1:0] cur_reg, cur_next;
    logic [CW-1:0] held_reg, held_next;
    logic [twe_pkg::NUM_SLOTS-1:0]   occ_reg, occ_next;
    logic [twe_pkg::NUM_WAITERS-1:0] act_reg, act_next;
    logic [CW-1:0] wheel_slots_reg, wheel_slots_next;
    logic [SW-1:0] s_reg, s_next;
    logic [SW-1:0] home_reg, home_next;
    logic [IW-1:0] nb_reg, nb_next;
    logic [IW-1:0] na_reg, na_next;
    logic [IW-1:0] first_reg, first_next;
    logic [IW-1:0] tail_reg, tail_next;
    logic          app_tail_reg, app_tail_next;
    logic [IW-1:0] walk_reg, walk_next;
    logic [IW-1:0] fin_reg, fin_next;
    logic [IW-1:0] nxt_reg, nxt_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          more_reg, more_next;
    twe_pkg::out_item_t out_reg, out_next;

    // Memory ports
    logic                               slot_we, wtr_we;
    logic [SW-1:0]                      slot_waddr, slot_raddr;
    logic [IW-1:0]                      wtr_waddr, wtr_raddr;
    logic [twe_pkg::SLOT_ENTRY_W-1:0]   slot_wdata, slot_rdata;
    logic [twe_pkg::WAITER_ENTRY_W-1:0] wtr_wdata, wtr_rdata;

    // Per-slot list head and tail
    twe_ram #(.WIDTH(twe_pkg::SLOT_ENTRY_W), .DEPTH(twe_pkg::NUM_SLOTS)) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    // Per-waiter links and home slot
    twe_ram #(.WIDTH(twe_pkg::WAITER_ENTRY_W), .DEPTH(twe_pkg::NUM_WAITERS)) u_wtr_ram (
        .clk   (clk),
        .we    (wtr_we),
        .waddr (wtr_waddr),
        .wdata (wtr_wdata),
        .raddr (wtr_raddr),
        .rdata (wtr_rdata)
    );

    // Field views of memory read data
    logic [IW-1:0] rd_first, rd_final, rd_after, rd_before;
    logic [SW-1:0] rd_home;
    assign rd_first  = slot_rdata[2*IW-1:IW];
    assign rd_final  = slot_rdata[IW-1:0];
    assign rd_after  = wtr_rdata[2*IW+SW-1:IW+SW];
    assign rd_before = wtr_rdata[IW+SW-1:SW];
    assign rd_home   = wtr_rdata[SW-1:0];

    // Handshakes: input only taken when idle, result held in out_reg
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign out_item  = out_reg;

    // APB: single register, decoded where paddr[2] is 0 (indices 0-3), always ready
    logic cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign prdata = (paddr[2] == 1'b0) ? {{(32-CW){1'b0}}, wheel_slots_reg} : 32'd0;

    // Effective slot count and the advanced slot for a tick
    logic [CW-1:0] slots_used, cur_inc, tick_slot7;
    logic [SW-1:0] tick_slot;
    always_comb
    begin
        if (wheel_slots_reg == '0)
        begin
            slots_used = CW'(1);
        end
        else if (wheel_slots_reg > MAXS)
        begin
            slots_used = MAXS;
        end
        else
        begin
            slots_used = wheel_slots_reg;
        end
        cur_inc    = {1'b0, cur_reg} + CW'(1);
        tick_slot7 = (cur_inc >= slots_used) ? '0 : cur_inc;
        tick_slot  = tick_slot7[SW-1:0];
    end

    logic [CW-1:0] cnt_inc;
    logic          walk_end;
    assign cnt_inc  = cnt_reg + CW'(1);
    assign walk_end = (walk_reg == fin_reg) || (cnt_inc >= FULL);

    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        id_next          = id_reg;
        cur_next         = cur_reg;
        held_next        = held_reg;
        occ_next         = occ_reg;
        act_next         = act_reg;
        wheel_slots_next = cfg_wr ? pwdata[CW-1:0] : wheel_slots_reg;
        s_next           = s_reg;
        home_next        = home_reg;
        nb_next          = nb_reg;
        na_next          = na_reg;
        first_next       = first_reg;
        tail_next        = tail_reg;
        app_tail_next    = app_tail_reg;
        walk_next        = walk_reg;
        fin_next         = fin_reg;
        nxt_next         = nxt_reg;
        cnt_next         = cnt_reg;
        more_next        = more_reg;
        out_next         = out_reg;

        slot_we    = 1'b0;
        slot_waddr = s_reg;
        slot_wdata = '0;
        slot_raddr = s_reg;
        wtr_we     = 1'b0;
        wtr_waddr  = id_reg;
        wtr_wdata  = '0;
        wtr_raddr  = id_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next = in_item.operation;
                    id_next = in_item.waiter_id;
                    out_next = '{status: twe_pkg::ST_OK, expired_valid: 1'b0,
                                 expired_id: '0, expired_count: '0,
                                 waiting_total: held_reg, last: 1'b1};
                    more_next = 1'b0;
                    unique case (in_item.operation)
                        twe_pkg::OP_TICK:
                        begin
                            // advance the hand, then walk the slot if it holds waiters
                            cur_next = tick_slot;
                            s_next   = tick_slot;
                            if (occ_reg[tick_slot])
                            begin
                                slot_raddr = tick_slot;
                                state_next = S_T_SLOT;
                            end
                            else
                            begin
                                state_next = S_OUT;
                            end
                        end
                        twe_pkg::OP_INSERT:
                        begin
                            if (act_reg[in_item.waiter_id])
                            begin
                                out_next.status = twe_pkg::ST_ERR;
                                state_next      = S_OUT;
                            end
                            else
                            begin
                                state_next = S_A_GO;
                            end
                        end
                        default:
                        begin
                            // refresh and remove both unlink first
                            if (!act_reg[in_item.waiter_id])
                            begin
                                out_next.status = twe_pkg::ST_ERR;
                                state_next      = S_OUT;
                            end
                            else
                            begin
                                wtr_raddr  = in_item.waiter_id;
                                state_next = S_U_W;
                            end
                        end
                    endcase
                end
            end

            S_U_W:
            begin
                home_next  = rd_home;
                nb_next    = rd_before;
                na_next    = rd_after;
                slot_raddr = rd_home;
                state_next = S_U_S;
            end

            S_U_S:
            begin
                slot_waddr = home_reg;
                state_next = S_U_DONE;
                priority if ((rd_first == id_reg) && (rd_final == id_reg))
                begin
                    occ_next[home_reg] = 1'b0;
                end
                else if (rd_first == id_reg)
                begin
                    slot_we    = 1'b1;
                    slot_wdata = {na_reg, rd_final};
                end
                else if (rd_final == id_reg)
                begin
                    slot_we    = 1'b1;
                    slot_wdata = {rd_first, nb_reg};
                end
                else
                begin
                    wtr_raddr  = nb_reg;
                    state_next = S_U_NB;
                end
            end

            S_U_NB:
            begin
                wtr_we     = 1'b1;
                wtr_waddr  = nb_reg;
                wtr_wdata  = {na_reg, rd_before, rd_home};
                state_next = S_U_NARD;
            end

            S_U_NARD:
            begin
                wtr_raddr  = na_reg;
                state_next = S_U_NA;
            end

            S_U_NA:
            begin
                wtr_we     = 1'b1;
                wtr_waddr  = na_reg;
                wtr_wdata  = {rd_after, nb_reg, rd_home};
                state_next = S_U_DONE;
            end

            S_U_DONE:
            begin
                act_next[id_reg] = 1'b0;
                if (op_reg == twe_pkg::OP_REMOVE)
                begin
                    if (held_reg != '0)
                    begin
                        held_next = held_reg - CW'(1);
                    end
                    out_next.waiting_total = (held_reg != '0) ? held_reg - CW'(1) : held_reg;
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_A_GO;
                end
            end

            S_A_GO:
            begin
                s_next = cur_reg;
                if (occ_reg[cur_reg])
                begin
                    slot_raddr = cur_reg;
                    state_next = S_A_S;
                end
                else
                begin
                    slot_we           = 1'b1;
                    slot_waddr        = cur_reg;
                    slot_wdata        = {id_reg, id_reg};
                    occ_next[cur_reg] = 1'b1;
                    app_tail_next     = 1'b0;
                    wtr_raddr         = id_reg;
                    state_next        = S_A_ID;
                end
            end

            S_A_S:
            begin
                first_next = rd_first;
                tail_next  = rd_final;
                wtr_raddr  = rd_final;
                state_next = S_A_TL;
            end

            S_A_TL:
            begin
                wtr_we        = 1'b1;
                wtr_waddr     = tail_reg;
                wtr_wdata     = {id_reg, rd_before, rd_home};
                slot_we       = 1'b1;
                slot_waddr    = s_reg;
                slot_wdata    = {first_reg, id_reg};
                app_tail_next = 1'b1;
                state_next    = S_A_RID;
            end

            S_A_RID:
            begin
                wtr_raddr  = id_reg;
                state_next = S_A_ID;
            end

            S_A_ID:
            begin
                wtr_we           = 1'b1;
                wtr_waddr        = id_reg;
                wtr_wdata        = {rd_after, (app_tail_reg ? tail_reg : rd_before), s_reg};
                act_next[id_reg] = 1'b1;
                if ((op_reg == twe_pkg::OP_INSERT) && (held_reg < FULL))
                begin
                    held_next              = held_reg + CW'(1);
                    out_next.waiting_total = held_reg + CW'(1);
                end
                state_next = S_OUT;
            end

            S_T_SLOT:
            begin
                walk_next        = rd_first;
                fin_next         = rd_final;
                occ_next[s_reg]  = 1'b0;
                cnt_next         = '0;
                wtr_raddr        = rd_first;
                state_next       = S_T_W;
            end

            S_T_W:
            begin
                // expire one waiter per pass; the last one carries the count
                act_next[walk_reg] = 1'b0;
                cnt_next           = cnt_inc;
                nxt_next           = rd_after;
                out_next.status        = twe_pkg::ST_OK;
                out_next.expired_valid = 1'b1;
                out_next.expired_id    = walk_reg;
                if (walk_end)
                begin
                    held_next              = (held_reg >= cnt_inc) ? held_reg - cnt_inc : '0;
                    out_next.expired_count = cnt_inc;
                    out_next.waiting_total = (held_reg >= cnt_inc) ? held_reg - cnt_inc : '0;
                    out_next.last          = 1'b1;
                    more_next              = 1'b0;
                end
                else
                begin
                    out_next.expired_count = '0;
                    out_next.waiting_total = held_reg;
                    out_next.last          = 1'b0;
                    more_next              = 1'b1;
                end
                state_next = S_OUT;
            end

            S_OUT:
            begin
                if (out_ready)
                begin
                    if (more_reg)
                    begin
                        walk_next  = nxt_reg;
                        wtr_raddr  = nxt_reg;
                        state_next = S_T_W;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            op_reg          <= '0;
            id_reg          <= '0;
            cur_reg         <= '0;
            held_reg        <= '0;
            occ_reg         <= '0;
            act_reg         <= '0;
            wheel_slots_reg <= MAXS;
            s_reg           <= '0;
            home_reg        <= '0;
            nb_reg          <= '0;
            na_reg          <= '0;
            first_reg       <= '0;
            tail_reg        <= '0;
            app_tail_reg    <= 1'b0;
            walk_reg        <= '0;
            fin_reg         <= '0;
            nxt_reg         <= '0;
            cnt_reg         <= '0;
            more_reg        <= 1'b0;
            out_reg         <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            op_reg          <= op_next;
            id_reg          <= id_next;
            cur_reg         <= cur_next;
            held_reg        <= held_next;
            occ_reg         <= occ_next;
            act_reg         <= act_next;
            wheel_slots_reg <= wheel_slots_next;
            s_reg           <= s_next;
            home_reg        <= home_next;
            nb_reg          <= nb_next;
            na_reg          <= na_next;
            first_reg       <= first_next;
            tail_reg        <= tail_next;
            app_tail_reg    <= app_tail_next;
            walk_reg        <= walk_next;
            fin_reg         <= fin_next;
            nxt_reg         <= nxt_next;
            cnt_reg         <= cnt_next;
            more_reg        <= more_next;
            out_reg         <= out_next;
        end
    end

    // Held count never exceeds the waiter population
    `TWE_NEVER(a_held_range, held_reg > FULL)
    // No new transaction is taken while a result is pending
    `TWE_NEVER(a_one_item, in_ready && out_valid)
    // Only tick walks give more than one result
    `TWE_ASSERT(a_more_on_tick, out_valid && !out_item.last |-> out_item.expired_valid)
    // A walk never runs past the waiter population
    `TWE_NEVER(a_walk_bound, (state_reg == S_T_W) && (cnt_reg >= FULL))

endmodule
